@@ hw/rtl/gewm_pkg.sv @@
// Shared types, constants and the sine table function for the envelope window mix core.
package gewm_pkg;

    localparam logic [15:0] Q15_ONE       = 16'd32768;
    localparam logic [24:0] Q24_ONE       = 25'd16777216;
    localparam logic [24:0] ENV_THRESHOLD = 25'd167772;
    localparam logic [31:0] HALF_PI_Q30   = 32'd1686629713;
    localparam logic [54:0] TINY_PRODUCT  = 55'd18014398510;
    localparam logic [31:0] RECIP5        = 32'hCCCCCCCD;
    localparam logic [49:0] ENV_ROUND     = 50'd8388608;
    localparam logic [54:0] MIX_ROUND     = 55'd274877906944;

    localparam logic [23:0] ATTACK_RESET  = 24'd16711680;
    localparam logic [23:0] RELEASE_RESET = 24'd16775000;
    localparam logic [16:0] WINDOW_RESET  = 17'd19200;

    localparam int unsigned CFG_DATA_W  = 24;
    localparam int unsigned CFG_INDEX_W = 2;

    // Rounded-up reciprocals of the Taylor divisors, exact for dividends below 2^33.
    localparam int unsigned RCP_SHIFT = 41;
    localparam logic [63:0] RCP_6     = ((64'd1 << RCP_SHIFT) + 64'd5) / 64'd6;
    localparam logic [63:0] RCP_20    = ((64'd1 << RCP_SHIFT) + 64'd19) / 64'd20;
    localparam logic [63:0] RCP_42    = ((64'd1 << RCP_SHIFT) + 64'd41) / 64'd42;
    localparam logic [63:0] RCP_72    = ((64'd1 << RCP_SHIFT) + 64'd71) / 64'd72;
    localparam logic [63:0] RCP_110   = ((64'd1 << RCP_SHIFT) + 64'd109) / 64'd110;
    localparam logic [63:0] RCP_156   = ((64'd1 << RCP_SHIFT) + 64'd155) / 64'd156;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ATTACK  = 2'd0,
        CFG_RELEASE = 2'd1,
        CFG_WINDOW  = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_MUL_TGT,
        OP_SET_TGT,
        OP_MUL_ENV,
        OP_MUL_TGT_W,
        OP_ENV,
        OP_ARM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ROM_GAIN,
        OP_SET_GAIN,
        OP_MUL_SD,
        OP_MUL_P,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic skip;   // zero window or zero diffusion
        logic zero;   // hold counter idle, result is zero
    } t_status;

    // Quarter-wave sine entry in Q1.15, evaluated at elaboration only.
    function automatic logic [15:0] sine_entry(input int unsigned idx, input int unsigned bits);
        logic [63:0]  a;
        logic [63:0]  a2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  rc;
        logic [127:0] q;
        logic [63:0]  r;
        int unsigned k;
        a    = (64'(idx) * 64'(HALF_PI_Q30)) >> bits;
        a2   = (a * a) >> 30;
        term = a;
        sum  = a;
        for (k = 1; k <= 6; k++) begin
            unique case (k)
                1:       rc = RCP_6;
                2:       rc = RCP_20;
                3:       rc = RCP_42;
                4:       rc = RCP_72;
                5:       rc = RCP_110;
                default: rc = RCP_156;
            endcase
            q    = 128'((term * a2) >> 30) * 128'(rc);
            term = 64'(q >> RCP_SHIFT);
            if (k[0]) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        r = (sum + 64'd16384) >> 15;
        return (r > 64'(Q15_ONE)) ? Q15_ONE : r[15:0];
    endfunction

endpackage

@@ hw/rtl/gewm_ctrl.sv @@
// Sequencer that steps the datapath through one item and owns the handshakes.
module gewm_ctrl #(
    parameter int unsigned SINE_TABLE_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  gewm_pkg::t_status i_status,
    output gewm_pkg::t_op    o_op
);

    localparam int unsigned STEP_W = $clog2(SINE_TABLE_BITS + 2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_STGT,
        S_MENV,
        S_MTGTW,
        S_ENV,
        S_ARM,
        S_DIVI,
        S_DIV,
        S_ROM,
        S_SETG,
        S_MSD,
        S_MP,
        S_OUT
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic                w_accept;
    logic                w_out_free;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_stall;
        o_op        = gewm_pkg::OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_op    = gewm_pkg::OP_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.skip) begin
                    o_op    = gewm_pkg::OP_CLEAR;
                    n_state = S_OUT;
                end else begin
                    o_op    = gewm_pkg::OP_MUL_TGT;
                    n_state = S_STGT;
                end
            end
            S_STGT: begin
                o_op    = gewm_pkg::OP_SET_TGT;
                n_state = S_MENV;
            end
            S_MENV: begin
                o_op    = gewm_pkg::OP_MUL_ENV;
                n_state = S_MTGTW;
            end
            S_MTGTW: begin
                o_op    = gewm_pkg::OP_MUL_TGT_W;
                n_state = S_ENV;
            end
            S_ENV: begin
                o_op    = gewm_pkg::OP_ENV;
                n_state = S_ARM;
            end
            S_ARM: begin
                o_op    = gewm_pkg::OP_ARM;
                n_state = S_DIVI;
            end
            S_DIVI: begin
                o_op    = gewm_pkg::OP_DIV_INIT;
                n_step  = '0;
                n_state = i_status.zero ? S_OUT : S_DIV;
            end
            S_DIV: begin
                o_op   = gewm_pkg::OP_DIV_STEP;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SINE_TABLE_BITS)) begin
                    n_state = S_ROM;
                end
            end
            S_ROM: begin
                o_op    = gewm_pkg::OP_ROM_GAIN;
                n_state = S_SETG;
            end
            S_SETG: begin
                o_op    = gewm_pkg::OP_SET_GAIN;
                n_state = S_MSD;
            end
            S_MSD: begin
                o_op    = gewm_pkg::OP_MUL_SD;
                n_state = S_MP;
            end
            S_MP: begin
                o_op    = gewm_pkg::OP_MUL_P;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (w_out_free) begin
                    o_op        = gewm_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

endmodule

@@ hw/rtl/gewm_dpath.sv @@
// Datapath: configuration registers, envelope state, shared multiplier, divider and sine table.
module gewm_dpath #(
    parameter int unsigned SINE_TABLE_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [gewm_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [gewm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [15:0]                          i_excite_level,
    input  logic [15:0]                          i_cluster_amount,
    input  logic [15:0]                          i_diffusion_level,
    input  gewm_pkg::t_op                        i_op,
    output gewm_pkg::t_status                    o_status,
    output logic [15:0]                          o_mix_level
);

    localparam int unsigned IDX_W     = SINE_TABLE_BITS + 1;
    localparam int unsigned ROM_DEPTH = (1 << SINE_TABLE_BITS) + 1;

    logic [23:0]       r_attack;
    logic [23:0]       r_release;
    logic [16:0]       r_window;
    logic [24:0]       r_env;
    logic [16:0]       r_counter;
    logic              r_zero;
    logic [15:0]       r_excite;
    logic [15:0]       r_cluster;
    logic [15:0]       r_diff;
    logic [24:0]       r_target;
    logic [23:0]       r_coef;
    logic [49:0]       r_acc;
    logic [63:0]       r_prod;
    logic [17:0]       r_rem;
    logic [IDX_W-1:0]  r_quot;
    logic [15:0]       r_sine;
    logic [24:0]       r_gain;
    logic [15:0]       r_mix;

    logic [15:0]       w_rom [ROM_DEPTH];
    logic [31:0]       w_mul_a;
    logic [31:0]       w_mul_b;
    logic              w_mul_en;
    logic [23:0]       w_coef_sel;
    logic [27:0]       w_env6;
    logic [49:0]       w_env_sum;
    logic [16:0]       w_arm_count;
    logic              w_rem_ge;
    logic [17:0]       w_rem_sub;
    logic [IDX_W-1:0]  w_idx;
    logic [54:0]       w_p;
    logic [54:0]       w_p_round;
    logic [16:0]       w_mix_raw;

    for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_rom
        localparam logic [15:0] ENTRY = gewm_pkg::sine_entry(gi, SINE_TABLE_BITS);
        assign w_rom[gi] = ENTRY;
    end

    function automatic logic [15:0] sat_q15(input logic [15:0] v);
        return (v > gewm_pkg::Q15_ONE) ? gewm_pkg::Q15_ONE : v;
    endfunction

    assign o_status.skip = (r_window == '0) || (r_diff == '0);
    assign o_status.zero = r_zero;
    assign o_mix_level   = r_mix;

    assign w_coef_sel  = (r_target > r_env) ? r_attack : r_release;
    assign w_env6      = {1'b0, r_env, 2'b00} + {2'b00, r_env, 1'b0};
    assign w_env_sum   = r_acc + r_prod[49:0];
    assign w_arm_count = (r_env > gewm_pkg::ENV_THRESHOLD) ? r_window : r_counter;
    assign w_rem_ge    = r_rem >= {1'b0, r_window};
    assign w_rem_sub   = w_rem_ge ? (r_rem - {1'b0, r_window}) : r_rem;
    assign w_idx       = (r_quot > IDX_W'(1 << SINE_TABLE_BITS))
                         ? IDX_W'(1 << SINE_TABLE_BITS) : r_quot;
    assign w_p         = r_prod[54:0];
    assign w_p_round   = w_p + gewm_pkg::MIX_ROUND;
    assign w_mix_raw   = {1'b0, w_p_round[54:39]};

    // shared 32x32 multiplier operand select
    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b1;
        unique case (i_op)
            gewm_pkg::OP_MUL_TGT: begin
                w_mul_a = {16'd0, r_excite};
                w_mul_b = {16'd0, r_cluster};
            end
            gewm_pkg::OP_MUL_ENV: begin
                w_mul_a = {8'd0, w_coef_sel};
                w_mul_b = {7'd0, r_env};
            end
            gewm_pkg::OP_MUL_TGT_W: begin
                w_mul_a = {7'd0, gewm_pkg::Q24_ONE - {1'b0, r_coef}};
                w_mul_b = {7'd0, r_target};
            end
            gewm_pkg::OP_ROM_GAIN: begin
                w_mul_a = {4'd0, w_env6};
                w_mul_b = gewm_pkg::RECIP5;
            end
            gewm_pkg::OP_MUL_SD: begin
                w_mul_a = {16'd0, r_sine};
                w_mul_b = {16'd0, r_diff};
            end
            gewm_pkg::OP_MUL_P: begin
                w_mul_a = r_prod[31:0];
                w_mul_b = {7'd0, r_gain};
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= 64'(w_mul_a) * 64'(w_mul_b);
        end
        unique case (i_op)
            gewm_pkg::OP_LOAD: begin
                r_excite  <= sat_q15(i_excite_level);
                r_cluster <= sat_q15(i_cluster_amount);
                r_diff    <= sat_q15(i_diffusion_level);
            end
            gewm_pkg::OP_SET_TGT: begin
                r_target <= r_prod[30:6];
            end
            gewm_pkg::OP_MUL_ENV: begin
                r_coef <= w_coef_sel;
            end
            gewm_pkg::OP_MUL_TGT_W: begin
                r_acc <= r_prod[49:0] + gewm_pkg::ENV_ROUND;
            end
            gewm_pkg::OP_DIV_INIT: begin
                r_rem  <= {1'b0, r_counter};
                r_quot <= '0;
            end
            gewm_pkg::OP_DIV_STEP: begin
                r_quot <= {r_quot[IDX_W-2:0], w_rem_ge};
                r_rem  <= {w_rem_sub[16:0], 1'b0};
            end
            gewm_pkg::OP_ROM_GAIN: begin
                r_sine <= w_rom[w_idx];
            end
            gewm_pkg::OP_SET_GAIN: begin
                r_gain <= (r_prod[59:34] > 26'(gewm_pkg::Q24_ONE))
                          ? gewm_pkg::Q24_ONE : r_prod[58:34];
            end
            gewm_pkg::OP_OUT: begin
                if (r_zero || (w_p < gewm_pkg::TINY_PRODUCT)) begin
                    r_mix <= '0;
                end else if (w_mix_raw > 17'(gewm_pkg::Q15_ONE)) begin
                    r_mix <= gewm_pkg::Q15_ONE;
                end else begin
                    r_mix <= w_mix_raw[15:0];
                end
            end
            default: begin
            end
        endcase
    end

    // configuration and hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= gewm_pkg::ATTACK_RESET;
            r_release <= gewm_pkg::RELEASE_RESET;
            r_window  <= gewm_pkg::WINDOW_RESET;
            r_env     <= '0;
            r_counter <= '0;
            r_zero    <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    gewm_pkg::CFG_ATTACK: begin
                        r_attack <= i_cfg_data;
                    end
                    gewm_pkg::CFG_RELEASE: begin
                        r_release <= i_cfg_data;
                    end
                    gewm_pkg::CFG_WINDOW: begin
                        r_window <= i_cfg_data[16:0];
                        // shrink the hold count with the window
                        if (r_counter > i_cfg_data[16:0]) begin
                            r_counter <= i_cfg_data[16:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            unique case (i_op)
                gewm_pkg::OP_CLEAR: begin
                    r_env     <= '0;
                    r_counter <= '0;
                    r_zero    <= 1'b1;
                end
                gewm_pkg::OP_ENV: begin
                    r_env <= w_env_sum[48:24];
                end
                gewm_pkg::OP_ARM: begin
                    r_counter <= w_arm_count;
                    r_zero    <= (w_arm_count == '0);
                end
                gewm_pkg::OP_OUT: begin
                    if (!r_zero) begin
                        r_counter <= r_counter - 17'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/gated_envelope_window_mix_core.sv @@
// Top level of the gated envelope window mix core.
// One item in, one mix level out. Each item runs through a sequencer that
// shares a single 32x32 multiplier and a one-bit-per-cycle divider; the
// divider takes SINE_TABLE_BITS + 1 steps between the load, multiply and
// envelope steps and the table and output steps. Items with zero diffusion
// or a zero window go from the check step straight to output, and items
// with an idle hold counter skip the divider, table and gain steps. The
// sequencer is back to idle as the result is written and takes the next
// item in the cycle after, so a new item is not taken before the last
// result is written; a result still waiting in the output register holds
// the next item in its last step until the output is taken. Configuration
// writes must go through the plain write port between items, while no item
// is in flight; the core itself does not enforce this.
module gated_envelope_window_mix_core #(
    parameter int unsigned SINE_TABLE_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gewm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [gewm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [15:0]                      i_excite_level,
    input  logic [15:0]                      i_cluster_amount,
    input  logic [15:0]                      i_diffusion_level,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [15:0]                      o_mix_level
);

    gewm_pkg::t_op     w_op;
    gewm_pkg::t_status w_status;

    gewm_ctrl #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_op     (w_op)
    );

    gewm_dpath #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_excite_level    (i_excite_level),
        .i_cluster_amount  (i_cluster_amount),
        .i_diffusion_level (i_diffusion_level),
        .i_op              (w_op),
        .o_status          (w_status),
        .o_mix_level       (o_mix_level)
    );

endmodule

@@ hw/rtl/gewm_checker.sv @@
// Port-level checks for the envelope window mix core, bound to the top level.
module gewm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic [gewm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input logic [gewm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic [15:0]                      i_excite_level,
    input logic [15:0]                      i_cluster_amount,
    input logic [15:0]                      i_diffusion_level,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [15:0]                      o_mix_level
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_mix_level))
        else $error("result changed while stalled");

    // mix level never exceeds unity
    a_mix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mix_level <= gewm_pkg::Q15_ONE))
        else $error("mix level above one");

    // an accepted item keeps the input side busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accept");

    // a new result only appears at the end of an item's work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without item in progress");

endmodule

bind gated_envelope_window_mix_core gewm_checker u_gewm_checker (.*);
